/* sv/alfr_pkg.sv */
// Shared constants and types of the addressed length frame receiver.
// No dependencies; the parser, the reader, the top level and the bench import this package.
`default_nettype none

package alfr_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int AW           = $clog2(BUFFER_DEPTH);
  localparam int BYTE_W       = 8;
  localparam int POS_W        = 6;
  localparam int OUT_TDATA_W  = 16;

  localparam logic [BYTE_W-1:0] HEADER_BYTE       = 8'hFF;
  localparam logic [BYTE_W-1:0] NODE_ADDR_RESET   = 8'h01;
  localparam logic [BYTE_W:0]   FRAME_OVERHEAD    = 9'd7;
  localparam logic [BYTE_W:0]   MAX_TOTAL         = 9'(BUFFER_DEPTH - 1);
  localparam logic [AW-1:0]     LEN_LO_POS        = AW'(2);
  localparam logic [AW-1:0]     LEN_HI_POS        = AW'(3);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ADDR,
    PH_LEN,
    PH_BODY
  } phase_e;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_READ,
    RD_LOAD
  } rd_state_e;

  typedef struct packed {
    logic          start;
    logic [AW-1:0] count;
  } emit_req_t;

endpackage

`default_nettype wire

/* sv/alfr_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Self-contained; used for the capture store of the frame receiver.
`default_nettype none

module alfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/alfr_parser.sv */
// Receive side: writes each byte into the capture store and tracks the frame.
// Depends on alfr_pkg; hands a completed frame length to the readout unit.
`default_nettype none

module alfr_parser import alfr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [BYTE_W-1:0] cfg_wdata_i,
  input  wire logic              rx_valid_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  output logic                   ram_we_o,
  output logic      [AW-1:0]     ram_waddr_o,
  output logic      [BYTE_W-1:0] ram_wdata_o,
  output emit_req_t              emit_o
);

  phase_e            phase_q, phase_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [AW-1:0]     exp_q, exp_d;
  logic [BYTE_W-1:0] len_lo_q, len_lo_d;
  logic [BYTE_W-1:0] node_addr_q;
  logic [AW-1:0]     wp_inc;
  logic [BYTE_W:0]   total;
  logic              too_long;

  assign wp_inc   = wp_q + 1'b1;
  assign total    = {1'b0, len_lo_q} + FRAME_OVERHEAD;
  // The high length byte alone already pushes the total past the store depth.
  assign too_long = (rx_byte_i != '0) || (total > MAX_TOTAL);

  assign ram_we_o    = rx_valid_i;
  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = rx_byte_i;

  always_comb begin
    phase_d      = phase_q;
    wp_d         = wp_q;
    exp_d        = exp_q;
    len_lo_d     = len_lo_q;
    emit_o.start = 1'b0;
    emit_o.count = exp_q;
    if (rx_valid_i) begin
      wp_d = wp_inc;
      unique case (phase_q)
        PH_HUNT: begin
          if (rx_byte_i == HEADER_BYTE) begin
            phase_d = PH_ADDR;
          end else begin
            wp_d = '0;
          end
        end
        PH_ADDR: begin
          if (rx_byte_i == node_addr_q) begin
            phase_d = PH_LEN;
          end else begin
            wp_d    = '0;
            phase_d = PH_HUNT;
          end
        end
        PH_LEN: begin
          if (wp_q == LEN_LO_POS) begin
            len_lo_d = rx_byte_i;
          end else if (wp_q == LEN_HI_POS) begin
            if (too_long) begin
              wp_d    = '0;
              phase_d = PH_HUNT;
            end else begin
              exp_d   = total[AW-1:0];
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (wp_inc == exp_q) begin
            emit_o.start = 1'b1;
            wp_d         = '0;
            exp_d        = '0;
            phase_d      = PH_HUNT;
          end
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      wp_q        <= '0;
      exp_q       <= '0;
      node_addr_q <= NODE_ADDR_RESET;
    end else begin
      phase_q <= phase_d;
      wp_q    <= wp_d;
      exp_q   <= exp_d;
      if (cfg_we_i) begin
        node_addr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_lo_q <= len_lo_d;
  end

endmodule

`default_nettype wire

/* sv/alfr_reader.sv */
// Readout side: reads a completed frame out of the capture store, byte by byte,
// into the output register. Depends on alfr_pkg.
`default_nettype none

module alfr_reader import alfr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  emit_req_t              emit_i,
  output logic                   busy_o,
  output logic                   ram_re_o,
  output logic      [AW-1:0]     ram_raddr_o,
  input  wire logic [BYTE_W-1:0] ram_rdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic      [BYTE_W-1:0] out_byte_o,
  output logic      [POS_W-1:0]  out_pos_o,
  output logic                   out_last_o
);

  rd_state_e         state_q, state_d;
  logic [AW-1:0]     k_q, k_d;
  logic [AW-1:0]     n_q, n_d;
  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;
  logic [POS_W-1:0]  pos_q;
  logic              last_q;
  logic              slot_free;
  logic              is_last;
  logic              load;

  assign slot_free = !valid_q || out_ready_i;
  assign is_last   = (k_q == n_q - 1'b1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      RD_IDLE: if (emit_i.start) state_d = RD_READ;
      RD_READ: state_d = RD_LOAD;
      RD_LOAD: begin
        if (slot_free) begin
          state_d = is_last ? RD_IDLE : RD_READ;
        end
      end
      default: state_d = RD_IDLE;
    endcase
  end

  always_comb begin
    k_d         = k_q;
    n_d         = n_q;
    ram_re_o    = 1'b0;
    load        = 1'b0;
    busy_o      = (state_q != RD_IDLE);
    ram_raddr_o = k_q;
    unique case (state_q)
      RD_IDLE: begin
        if (emit_i.start) begin
          k_d = '0;
          n_d = emit_i.count;
        end
      end
      RD_READ: ram_re_o = 1'b1;
      RD_LOAD: begin
        if (slot_free) begin
          load = 1'b1;
          k_d  = k_q + 1'b1;
        end
      end
      default: ;
    endcase
    valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= RD_IDLE;
      k_q     <= '0;
      n_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      n_q     <= n_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= ram_rdata_i;
      pos_q  <= POS_W'(k_q);
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_pos_o   = pos_q;
  assign out_last_o  = last_q;

endmodule

`default_nettype wire

/* sv/addressed_length_frame_receiver_core.sv */
// Top level of the addressed length frame receiver.
// Depends on alfr_pkg, alfr_ram, alfr_parser and alfr_reader.
//
// Usage:
// The slave stream carries one received serial byte per request. A frame is
// 0xFF, the node address, a little-endian 16-bit length, then the body; its
// total size is the length plus 7 bytes. A frame too large for the store, a
// bad header byte or a foreign address sends the receiver back to hunting.
// Every byte is written into a 64-entry capture RAM at the current position.
// While receiving, one byte is taken per cycle.
// When the final byte of a frame is accepted, the frame is read back from the
// RAM and sent on the master stream, one request per byte: tdata carries the
// byte and its position in the frame, tlast marks the final byte. Each byte
// is fetched in a RAM read state, then loaded into the output register in a
// load state that waits while that register holds a byte not yet taken. The
// input is held off for the whole readout, which uses the single RAM read
// port; s_tready_o is low until the last byte sits in the output register. A
// stalled receiver holds the output register and the readout waits. After
// reset the receiver hunts for a header, the node address is 1, and the RAM
// contents are unknown, which is harmless since only entries written in the
// current frame are read. The cfg port writes the node address.
`default_nettype none

module addressed_length_frame_receiver_core import alfr_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [BYTE_W-1:0]      cfg_wdata_i,
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  input  wire logic [BYTE_W-1:0]      s_tdata_i,   // [7:0] rx_byte
  output logic                        m_tvalid_o,
  input  wire logic                   m_tready_i,
  output logic      [OUT_TDATA_W-1:0] m_tdata_o,   // [7:0] frame_byte, [13:8] byte_position
  output logic                        m_tlast_o    // last_of_frame
);

  emit_req_t         emit;
  logic              busy;
  logic              rx_accept;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] out_byte;
  logic [POS_W-1:0]  out_pos;

  // Input is blocked for the whole readout so the RAM never sees a write
  // and a read of the same frame at once.
  assign s_tready_o = !busy;
  assign rx_accept  = s_tvalid_i && s_tready_o;

  alfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .rx_valid_i  (rx_accept),
    .rx_byte_i   (s_tdata_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .emit_o      (emit)
  );

  alfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  alfr_reader u_reader (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .busy_o      (busy),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_byte_o  (out_byte),
    .out_pos_o   (out_pos),
    .out_last_o  (m_tlast_o)
  );

  assign m_tdata_o = {{(OUT_TDATA_W - POS_W - BYTE_W){1'b0}}, out_pos, out_byte};

  // A completed frame must shut the input for the readout that follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.start |=> !s_tready_o)
    else $error("input not held off after frame completion");

  // The capture RAM is never written and read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("capture RAM written during readout");

  // A completed frame always holds at least the header, address and length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit.start |-> (emit.count > LEN_HI_POS))
    else $error("completed frame shorter than its header");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for addressed_length_frame_receiver_core.
// Depends on alfr_pkg and the block's RTL. It streams serial bytes in, predicts
// every completed frame on the side, and compares each output request.
`default_nettype none

module testbench;
  import alfr_pkg::*;

  // No request may be missing for this many cycles. The longest quiet spell
  // of a correct run is the drain at the end.
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int DRAIN_CYCLES  = 160;
  localparam int PHASE_ITEMS   = 65;
  localparam int NUM_PHASES    = 5;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_byte_t;

  logic                   clk_i     = 1'b0;
  logic                   rst_ni    = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [BYTE_W-1:0]      cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [BYTE_W-1:0]      s_tdata   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  // Shadow copy of the receiver: capture store, write position, phase,
  // accepted frame size and the node address last written.
  logic [BYTE_W-1:0] rx_store [BUFFER_DEPTH];
  logic [6:0]        rx_pos;
  phase_e            rx_phase;
  logic [6:0]        rx_total;
  logic [BYTE_W-1:0] node_addr;

  frame_byte_t       frame_out_due [$];  // predicted frame bytes, oldest first
  logic [BYTE_W-1:0] rx_backlog [$];     // bytes waiting to be sent

  int   errors      = 0;
  int   idle_cycles = 0;
  int   in_wait     = 0;
  int   in_calm     = 0;
  int   out_wait    = 0;
  int   out_calm    = 0;
  logic in_took     = 1'b0;
  logic out_took    = 1'b0;

  always #4 clk_i = ~clk_i;

  addressed_length_frame_receiver_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .s_tvalid_i  (s_tvalid),
    .s_tready_o  (s_tready),
    .s_tdata_i   (s_tdata),
    .m_tvalid_o  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_o   (m_tdata),
    .m_tlast_o   (m_tlast)
  );

  // Applies one received byte to the shadow receiver. A completed frame
  // queues one expected output request per stored byte.
  function automatic void absorb_rx_byte(logic [BYTE_W-1:0] b);
    logic [16:0] len_total;
    frame_byte_t fb;
    if (rx_pos >= 7'(BUFFER_DEPTH)) rx_pos = '0;
    rx_store[rx_pos[AW-1:0]] = b;
    rx_pos = rx_pos + 7'd1;
    case (rx_phase)
      PH_HUNT: begin
        if (rx_store[0] == HEADER_BYTE) rx_phase = PH_ADDR;
        else rx_pos = '0;
      end
      PH_ADDR: begin
        if (rx_store[1] == node_addr) begin
          rx_phase = PH_LEN;
        end else begin
          rx_pos   = '0;
          rx_phase = PH_HUNT;
        end
      end
      PH_LEN: begin
        // The size check must see the carry out of the 16-bit length.
        if (rx_pos == 7'd4) begin
          len_total = {1'b0, rx_store[3], rx_store[2]} + 17'(FRAME_OVERHEAD);
          if (len_total > 17'(MAX_TOTAL)) begin
            rx_pos   = '0;
            rx_phase = PH_HUNT;
          end else begin
            rx_total = len_total[6:0];
            rx_phase = PH_BODY;
          end
        end
      end
      default: begin
        if (rx_pos == rx_total) begin
          for (int k = 0; k < int'(rx_total); k++) begin
            fb.data = rx_store[k];
            fb.pos  = POS_W'(k);
            fb.last = (k + 1 == int'(rx_total));
            frame_out_due.push_back(fb);
          end
          rx_pos   = '0;
          rx_total = '0;
          rx_phase = PH_HUNT;
        end
      end
    endcase
  endfunction

  // Cycles to wait before the next request on one side. Now and then a calm
  // stretch without any idling is started.
  function automatic int draw_wait(bit out_side);
    int calm;
    calm = out_side ? out_calm : in_calm;
    if (calm == 0 && $urandom_range(0, 19) == 0) calm = $urandom_range(8, 40);
    if (calm > 0) begin
      if (out_side) out_calm = calm - 1;
      else in_calm = calm - 1;
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  task automatic push_head(logic [BYTE_W-1:0] addr, logic [15:0] len);
    rx_backlog.push_back(HEADER_BYTE);
    rx_backlog.push_back(addr);
    rx_backlog.push_back(len[7:0]);
    rx_backlog.push_back(len[15:8]);
  endtask

  task automatic push_noise(int n);
    for (int i = 0; i < n; i++) rx_backlog.push_back(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed frames with random bodies, mixed with stray bytes,
  // foreign addresses, oversize lengths and frames cut short.
  task automatic queue_random_traffic(logic [BYTE_W-1:0] addr, int budget);
    int queued;
    int len;
    int cut;
    queued = 0;
    while (queued < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          case ($urandom_range(0, 9))
            0:       len = 56;
            1, 2:    len = $urandom_range(13, 55);
            default: len = $urandom_range(0, 12);
          endcase
          push_head(addr, 16'(len));
          push_noise(len + 3);
          queued += len + 7;
        end
        6: begin
          // A few stray bytes between frames.
          cut = $urandom_range(1, 4);
          push_noise(cut);
          queued += cut;
        end
        7: begin
          rx_backlog.push_back(HEADER_BYTE);
          rx_backlog.push_back(addr ^ BYTE_W'($urandom_range(1, 255)));
          queued += 2;
        end
        8: begin
          len = $urandom_range(0, 1) ? $urandom_range(57, 70) : $urandom_range(57, 65535);
          push_head(addr, 16'(len));
          queued += 4;
        end
        default: begin
          len = $urandom_range(0, 30);
          cut = $urandom_range(0, len + 2);
          push_head(addr, 16'(len));
          push_noise(cut);
          queued += 4 + cut;
        end
      endcase
    end
  endtask

  // Returns once every byte is sent and every predicted byte has come back.
  task automatic wait_idle();
    while (rx_backlog.size() != 0 || s_tvalid || frame_out_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Input driver. A byte stays on the bus until its request is taken, then
  // the drawn gap passes before the next one goes out.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || in_took)) begin
      if (in_wait > 0) begin
        s_tvalid <= 1'b0;
        in_wait  <= in_wait - 1;
      end else if (rx_backlog.size() > 0) begin
        s_tdata  <= rx_backlog.pop_front();
        s_tvalid <= 1'b1;
        in_wait  <= draw_wait(1'b0);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure: after each accepted result a stall is drawn.
  always @(negedge clk_i) begin : ready_gen
    int w;
    if (rst_ni) begin
      w = out_wait;
      if (out_took) w = draw_wait(1'b1);
      if (w > 0) begin
        m_tready <= 1'b0;
        out_wait <= w - 1;
      end else begin
        m_tready <= 1'b1;
        out_wait <= 0;
      end
    end
  end

  // Monitor: updates the prediction on every input request, checks every
  // output request against the oldest prediction, and runs the watchdog.
  always @(posedge clk_i) begin : monitor
    frame_byte_t want;
    if (rst_ni) begin
      in_took  <= s_tvalid && s_tready;
      out_took <= m_tvalid && m_tready;
      if (s_tvalid && s_tready) absorb_rx_byte(s_tdata);
      if (m_tvalid && m_tready) begin
        if (frame_out_due.size() == 0) begin
          $error("unexpected frame byte %0h at position %0d",
                 m_tdata[BYTE_W-1:0], m_tdata[BYTE_W +: POS_W]);
          errors++;
        end else begin
          want = frame_out_due.pop_front();
          if (m_tdata[BYTE_W-1:0] !== want.data) begin
            $error("frame_byte: expected %0h, got %0h", want.data, m_tdata[BYTE_W-1:0]);
            errors++;
          end
          if (m_tdata[BYTE_W +: POS_W] !== want.pos) begin
            $error("byte_position: expected %0d, got %0d", want.pos,
                   m_tdata[BYTE_W +: POS_W]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("last_of_frame: expected %0b, got %0b", want.last, m_tlast);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    logic [BYTE_W-1:0] cfg_plan [NUM_PHASES];
    cfg_plan = '{NODE_ADDR_RESET, 8'h00, 8'hFF, BYTE_W'($urandom_range(0, 255)),
                 NODE_ADDR_RESET};
    rx_pos    = '0;
    rx_total  = '0;
    rx_phase  = PH_HUNT;
    node_addr = NODE_ADDR_RESET;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // The first phase runs on the reset address; later ones write it while
      // the receiver is idle.
      if (p > 0) begin
        @(negedge clk_i);
        cfg_we    <= 1'b1;
        cfg_wdata <= cfg_plan[p];
        @(negedge clk_i);
        cfg_we    <= 1'b0;
        node_addr = cfg_plan[p];
      end
      if (p == 0) begin
        rx_backlog.push_back(8'h00);              // bad header byte
        rx_backlog.push_back(HEADER_BYTE);        // foreign address
        rx_backlog.push_back(8'h02);
        push_head(NODE_ADDR_RESET, 16'd57);       // total one past the store
        push_head(NODE_ADDR_RESET, 16'hFFFC);     // total carries out of 16 bits
        push_head(NODE_ADDR_RESET, 16'h0100);     // only the high length byte set
        push_head(NODE_ADDR_RESET, 16'd0);        // smallest frame
        rx_backlog.push_back(8'h00);
        rx_backlog.push_back(8'hFF);
        rx_backlog.push_back(8'h80);
      end
      if (p == 2) begin
        // Largest frame the store can hold.
        push_head(node_addr, 16'd56);
        push_noise(59);
      end
      queue_random_traffic(node_addr, PHASE_ITEMS);
      wait_idle();
    end

    // Anything arriving after the last frame is a failure.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (frame_out_due.size() != 0) begin
      $error("%0d predicted frame bytes never arrived", frame_out_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
